// ----- rtl/rqps_pkg.sv -----
package rqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int MODE_W      = 2;
    localparam int KEY_W       = 16;

    localparam logic [MODE_W-1:0] MODE_ARRIVAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHORTEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_WALK,
        S_PLACE,
        S_DEQ,
        S_DEQ_DATA,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_id;
        logic [7:0]  task_priority;
        logic [15:0] task_burst;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       next_task;
        logic             next_valid;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       tid;
        logic [KEY_W-1:0] key;
    } t_slot;

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = (CNT_W + OCC_W)'(cnt);
        return wide[OCC_W-1:0];
    endfunction

endpackage

// ----- rtl/rqps_ram.sv -----
module rqps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ready_queue_policy_scheduler.sv -----
// Ready queue of up to QUEUE_DEPTH task ids held in one single-port-read RAM as a ring.
// The policy register picks arrival order or an ascending sort on burst time or priority;
// ties keep arrival order. One transaction in, one result out, one item at a time: an
// item is taken in the idle cycle. A dequeue then reads the head entry and takes its data,
// or skips the data step when the queue is empty. An arrival-order enqueue, a dropped
// enqueue or a sorted enqueue into an empty queue only writes the entry or drops it. A sorted
// enqueue into a nonempty queue walks down from the tail past each queued entry whose key
// exceeds the new key, moving one entry per cycle through the RAM read and write ports,
// then writes the new entry. A full, stalled result register holds the block in its finish state.
module ready_queue_policy_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  rqps_pkg::t_in_item            i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output rqps_pkg::t_out_item           o_out_data,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_valid,
    input  logic [rqps_pkg::MODE_W-1:0]   i_cfg_data,
    output logic                          o_cfg_ready
);

    import rqps_pkg::*;

    t_state           r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_slot            r_item, n_item;
    logic             r_sorted, n_sorted;
    logic [7:0]       r_res_task, n_res_task;
    logic             r_res_valid, n_res_valid;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_accept;
    logic             w_full;
    logic             w_gt;
    logic             w_load;
    logic [IDX_W-1:0] w_cnt_idx;
    logic             w_we, w_re;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    t_slot            w_wdata;
    t_slot            w_rd;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    rqps_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_gt      = (w_rd.key > r_item.key);
    assign w_load    = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign w_cnt_idx = r_count[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.opcode == OP_DEQUEUE) ? S_DEQ : S_ENQ;
                end
            end
            S_ENQ: begin
                if (w_full || !r_sorted || r_count == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!w_gt) begin
                    n_state = S_FINISH;
                end else if (r_idx == '0) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE:    n_state = S_FINISH;
            S_DEQ:      n_state = (r_count == '0) ? S_FINISH : S_DEQ_DATA;
            S_DEQ_DATA: n_state = S_FINISH;
            S_FINISH: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_head       = r_head;
        n_idx        = r_idx;
        n_item       = r_item;
        n_sorted     = r_sorted;
        n_res_task   = r_res_task;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = r_item;
        w_re         = 1'b0;
        w_raddr      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item.tid = i_in_data.task_id;
                    n_sorted   = (r_mode == MODE_SHORTEST) || (r_mode == MODE_PRIORITY);
                    if (r_mode == MODE_SHORTEST) begin
                        n_item.key = i_in_data.task_burst;
                    end else if (r_mode == MODE_PRIORITY) begin
                        n_item.key = KEY_W'(i_in_data.task_priority);
                    end else begin
                        n_item.key = '0;
                    end
                end
            end
            S_ENQ: begin
                n_res_task   = '0;
                n_res_valid  = 1'b0;
                n_res_status = ST_OK;
                if (w_full) begin
                    n_res_status = ST_FULL;
                end else if (!r_sorted || r_count == '0) begin
                    w_we    = 1'b1;
                    w_waddr = phys(r_head, w_cnt_idx);
                    n_count = r_count + CNT_W'(1);
                end else begin
                    w_re    = 1'b1;
                    w_raddr = phys(r_head, w_cnt_idx - IDX_W'(1));
                    n_idx   = w_cnt_idx - IDX_W'(1);
                end
            end
            S_WALK: begin
                w_re    = (r_idx != '0);
                w_raddr = phys(r_head, r_idx - IDX_W'(1));
                w_we    = 1'b1;
                w_waddr = phys(r_head, r_idx + IDX_W'(1));
                if (w_gt) begin
                    w_wdata = w_rd;
                    if (r_idx != '0) begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_waddr = r_head;
                n_count = r_count + CNT_W'(1);
            end
            S_DEQ: begin
                n_res_task  = '0;
                n_res_valid = 1'b0;
                if (r_count == '0) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    n_res_status = ST_OK;
                    w_re         = 1'b1;
                    w_raddr      = r_head;
                end
            end
            S_DEQ_DATA: begin
                n_res_task  = w_rd.tid;
                n_res_valid = 1'b1;
                n_count     = r_count - CNT_W'(1);
                n_head      = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_head + IDX_W'(1);
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_ARRIVAL;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_item       <= n_item;
        r_sorted     <= n_sorted;
        r_res_task   <= n_res_task;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
        if (w_load) begin
            r_out_data.next_task  <= r_res_task;
            r_out_data.next_valid <= r_res_valid;
            r_out_data.status     <= r_res_status;
            r_out_data.occupancy  <= occ_of(r_count);
        end
    end

endmodule

// ----- rtl/rqps_chk.sv -----
module rqps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input rqps_pkg::t_out_item         o_out_data,
    input logic                        i_out_stall
);

    import rqps_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took a second transaction without a busy cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_task_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.next_valid ? (o_out_data.status == ST_OK)
                                               : (o_out_data.next_task == '0)))
        else $error("next_task and next_valid disagree with status");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.occupancy == occ_of(CNT_W'(QUEUE_DEPTH)))
        else $error("dropped enqueue without a full queue");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |-> o_out_data.occupancy == '0)
        else $error("empty dequeue with tasks queued");

endmodule

bind ready_queue_policy_scheduler rqps_chk u_rqps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
